FILE: design/soft_label_cross_entropy_loss_defines.svh
// Assertion macros used by the checker file.
`ifndef SOFT_LABEL_CROSS_ENTROPY_LOSS_DEFINES_SVH
`define SOFT_LABEL_CROSS_ENTROPY_LOSS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define SLCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slce check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define SLCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slce check failed");

`endif

FILE: design/slce_pkg.sv
// Types, constants and the log2 mantissa table of the soft-label loss block.
package slce_pkg;

    localparam int PROB_FRAC_BITS = 16;
    localparam int LN_TABLE_BITS  = 8;
    localparam int LN_ROM_DEPTH   = 1 << LN_TABLE_BITS;
    localparam int ROM_W          = 31;
    localparam int LOG_W          = $clog2(PROB_FRAC_BITS);
    localparam int SHIFT_W        = 3;
    localparam int REM_W          = 7;
    localparam int NLN_W          = 29;
    localparam int SUM_W          = 48;
    localparam int MEAN_W         = 40;
    localparam int NORM_W         = 41;
    localparam int TERM_W         = 23;
    localparam int CNT_W          = 6;

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] RECIP_255 = 32'h80808081;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(SUM_W);

    // configuration register indexes
    localparam logic [1:0] REG_NORM_MODE   = 2'd0;
    localparam logic [1:0] REG_BATCH_COUNT = 2'd1;
    localparam logic [1:0] REG_PIXELS      = 2'd2;

    // normalizer modes
    localparam logic [1:0] NORM_FULL  = 2'd0;
    localparam logic [1:0] NORM_VALID = 2'd1;
    localparam logic [1:0] NORM_BATCH = 2'd2;
    localparam logic [1:0] NORM_NONE  = 2'd3;

    typedef struct packed {
        logic [7:0]                label_byte;
        logic [PROB_FRAC_BITS-1:0] fg_prob;
        logic [PROB_FRAC_BITS-1:0] bg_prob;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_loss;
        logic              saturated;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic ln_step1;
        logic ln_step2;
        logic ln_step3;
        logic ln_bg;
        logic term_step1;
        logic term_step2;
        logic acc;
        logic norm_load;
        logic div_init;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } dp_status_t;

    typedef logic [LN_ROM_DEPTH-1:0][ROM_W-1:0] ln_rom_t;

    // log2(1 + i/2^LN_TABLE_BITS) in Q30 by repeated squaring, truncated
    function automatic logic [ROM_W-1:0] log2_mant(int i);
        logic [63:0] y;
        logic [63:0] r;
        y = (64'd1 << 30) + (64'(i) << (30 - LN_TABLE_BITS));
        r = 64'd0;
        for (int k = 0; k < 30; k++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                r = r | 64'd1;
            end
        end
        return r[ROM_W-1:0];
    endfunction

    function automatic ln_rom_t build_rom();
        ln_rom_t t;
        for (int i = 0; i < LN_ROM_DEPTH; i++) begin
            t[i] = log2_mant(i);
        end
        return t;
    endfunction

    localparam ln_rom_t LN_ROM = build_rom();

endpackage

FILE: design/slce_ctrl.sv
// Soft-label loss sequencer: steps the datapath through a pixel and the mean.
module slce_ctrl
    import slce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_F1    = 4'd1;
    localparam logic [3:0] ST_F2    = 4'd2;
    localparam logic [3:0] ST_F3    = 4'd3;
    localparam logic [3:0] ST_B1    = 4'd4;
    localparam logic [3:0] ST_B2    = 4'd5;
    localparam logic [3:0] ST_B3    = 4'd6;
    localparam logic [3:0] ST_T1    = 4'd7;
    localparam logic [3:0] ST_T2    = 4'd8;
    localparam logic [3:0] ST_ACC   = 4'd9;
    localparam logic [3:0] ST_NORM  = 4'd10;
    localparam logic [3:0] ST_DINIT = 4'd11;
    localparam logic [3:0] ST_DIV   = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_F1;
                end
            end
            ST_F1:
            begin
                cmd.ln_step1 = 1'b1;
                state_next   = ST_F2;
            end
            ST_F2:
            begin
                cmd.ln_step2 = 1'b1;
                state_next   = ST_F3;
            end
            ST_F3:
            begin
                cmd.ln_step3 = 1'b1;
                state_next   = ST_B1;
            end
            ST_B1:
            begin
                cmd.ln_step1 = 1'b1;
                cmd.ln_bg    = 1'b1;
                state_next   = ST_B2;
            end
            ST_B2:
            begin
                cmd.ln_step2 = 1'b1;
                state_next   = ST_B3;
            end
            ST_B3:
            begin
                cmd.ln_step3 = 1'b1;
                cmd.ln_bg    = 1'b1;
                state_next   = ST_T1;
            end
            ST_T1:
            begin
                cmd.term_step1 = 1'b1;
                state_next     = ST_T2;
            end
            ST_T2:
            begin
                cmd.term_step2 = 1'b1;
                state_next     = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? ST_NORM : ST_IDLE;
            end
            ST_NORM:
            begin
                cmd.norm_load = 1'b1;
                state_next    = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST_STEP)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the previous result has been taken
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: design/slce_dp.sv
// Datapath of the soft-label loss block: log unit, pixel term, accumulator, divider.
module slce_dp
    import slce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    // configuration
    logic [1:0]  norm_mode_reg;
    logic [15:0] batch_count_reg;
    logic [24:0] pixels_reg;

    // captured item
    logic [7:0]                label_reg;
    logic [PROB_FRAC_BITS-1:0] fg_reg, bg_reg;
    logic                      last_reg;

    // log unit stage 1
    logic [PROB_FRAC_BITS-1:0] x;
    logic [LOG_W-1:0]          m;
    logic [PROB_FRAC_BITS-1:0] frac;
    logic [SHIFT_W-1:0]        r;
    logic [LN_TABLE_BITS-1:0]  idx;
    logic [REM_W-1:0]          rem;
    logic [LOG_W-1:0]          m1_reg;
    logic [SHIFT_W-1:0]        r1_reg;
    logic [REM_W-1:0]          rem1_reg;
    logic [ROM_W-1:0]          lo1_reg, hi1_reg;

    // log unit stage 2
    logic [ROM_W-1:0]       diff;
    logic [ROM_W+REM_W-1:0] dprod;
    logic [ROM_W-1:0]       interp;
    logic [LOG_W-1:0]       m2_reg;
    logic [ROM_W-1:0]       interp2_reg;

    // log unit stage 3
    logic [34:0]      v;
    logic [34:0]      vr;
    logic [58:0]      lnprod;
    logic [NLN_W-1:0] a_reg, b_reg;

    // pixel term
    logic [37:0]       n_sum;
    logic [37:0]       n_reg;
    logic [61:0]       qprod;
    logic [TERM_W-1:0] term_reg;

    // accumulator
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_reg;
    logic             sat_reg;

    // normalizer and divider
    logic [NORM_W-1:0] norm_full;
    logic [NORM_W-1:0] norm_sel;
    logic [NORM_W-1:0] norm_reg;
    logic [NORM_W:0]   rem_div_reg;
    logic [SUM_W:0]    quo_reg;
    logic [NORM_W:0]   trial;
    logic              fit;

    logic out_valid_reg;
    out_item_t out_item_reg;

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

    // stage 1: top bit, table index and remainder
    always_comb
    begin
        x = cmd.ln_bg ? bg_reg : fg_reg;
        m = '0;
        for (int t = 0; t < PROB_FRAC_BITS; t++)
        begin
            if (x[t])
            begin
                m = LOG_W'(t);
            end
        end
        frac = x - (PROB_FRAC_BITS'(1) << m);
        if (m >= LOG_W'(LN_TABLE_BITS))
        begin
            r   = SHIFT_W'(m - LOG_W'(LN_TABLE_BITS));
            idx = LN_TABLE_BITS'(frac >> r);
            rem = REM_W'(frac & ((PROB_FRAC_BITS'(1) << r) - 1'b1));
        end
        else
        begin
            r   = '0;
            idx = LN_TABLE_BITS'(frac << (LOG_W'(LN_TABLE_BITS) - m));
            rem = '0;
        end
    end

    // stage 2: linear interpolation between neighbor entries
    always_comb
    begin
        diff   = hi1_reg - lo1_reg;
        dprod  = (ROM_W+REM_W)'(diff) * (ROM_W+REM_W)'(rem1_reg);
        interp = lo1_reg + ROM_W'(dprod >> r1_reg);
    end

    // stage 3: -log2 in Q30, round to Q24, scale by ln 2
    always_comb
    begin
        v      = ((35'(PROB_FRAC_BITS) - 35'(m2_reg)) << 30) - 35'(interp2_reg);
        vr     = (v + 35'd32) >> 6;
        lnprod = 59'(vr[NLN_W-1:0]) * 59'(LN2_Q30);
    end

    // pixel term: weighted sum, then divide by 65280 as shift by 8 and divide by 255
    always_comb
    begin
        n_sum = 38'(label_reg) * 38'(a_reg)
              + 38'(8'd255 - label_reg) * 38'(b_reg) + 38'd32640;
        qprod = 62'(n_reg[37:8]) * 62'(RECIP_255);
    end

    always_comb
    begin
        sum_ext   = {1'b0, sum_reg} + (SUM_W+1)'(term_reg);
        norm_full = NORM_W'(batch_count_reg) * NORM_W'(pixels_reg);
        case (norm_mode_reg)
            NORM_BATCH: norm_sel = NORM_W'(batch_count_reg);
            NORM_NONE:  norm_sel = NORM_W'(1);
            default:    norm_sel = norm_full;
        endcase
        trial = {rem_div_reg[NORM_W-1:0], quo_reg[SUM_W]};
        fit   = (trial >= (NORM_W+1)'(norm_reg));
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg   <= NORM_VALID;
            batch_count_reg <= 16'd1;
            pixels_reg      <= 25'd1;
            sum_reg         <= '0;
            sat_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NORM_MODE:   norm_mode_reg   <= cfg_data[1:0];
                    REG_BATCH_COUNT: batch_count_reg <= cfg_data[15:0];
                    REG_PIXELS:      pixels_reg      <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.acc)
            begin
                if (sum_ext > (SUM_W+1)'(SUM_MAX))
                begin
                    sum_reg <= SUM_MAX;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_ext[SUM_W-1:0];
                end
            end
            else if (cmd.out_load)
            begin
                sum_reg <= '0;
                sat_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            label_reg <= in_item.label_byte;
            fg_reg    <= (in_item.fg_prob == '0) ? PROB_FRAC_BITS'(1) : in_item.fg_prob;
            bg_reg    <= (in_item.bg_prob == '0) ? PROB_FRAC_BITS'(1) : in_item.bg_prob;
            last_reg  <= in_item.last;
        end
        if (cmd.ln_step1)
        begin
            m1_reg   <= m;
            r1_reg   <= r;
            rem1_reg <= rem;
            lo1_reg  <= LN_ROM[idx];
            hi1_reg  <= (idx == {LN_TABLE_BITS{1'b1}}) ? (ROM_W'(1) << 30)
                                                     : LN_ROM[idx + 1'b1];
        end
        if (cmd.ln_step2)
        begin
            m2_reg      <= m1_reg;
            interp2_reg <= interp;
        end
        if (cmd.ln_step3)
        begin
            if (cmd.ln_bg)
            begin
                b_reg <= NLN_W'((lnprod + (59'd1 << 29)) >> 30);
            end
            else
            begin
                a_reg <= NLN_W'((lnprod + (59'd1 << 29)) >> 30);
            end
        end
        if (cmd.term_step1)
        begin
            n_reg <= n_sum;
        end
        if (cmd.term_step2)
        begin
            term_reg <= TERM_W'(qprod >> 39);
        end
        if (cmd.norm_load)
        begin
            norm_reg <= (norm_sel == '0) ? NORM_W'(1) : norm_sel;
        end
        if (cmd.div_init)
        begin
            quo_reg     <= (SUM_W+1)'(sum_reg) + (SUM_W+1)'(norm_reg >> 1);
            rem_div_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_div_reg <= fit ? (trial - (NORM_W+1)'(norm_reg)) : trial;
            quo_reg     <= {quo_reg[SUM_W-1:0], fit};
        end
        if (cmd.out_load)
        begin
            if (quo_reg > (SUM_W+1)'({MEAN_W{1'b1}}))
            begin
                out_item_reg.mean_loss <= {MEAN_W{1'b1}};
                out_item_reg.saturated <= 1'b1;
            end
            else
            begin
                out_item_reg.mean_loss <= quo_reg[MEAN_W-1:0];
                out_item_reg.saturated <= sat_reg;
            end
        end
    end

endmodule

FILE: design/soft_label_cross_entropy_loss.sv
// Soft-label cross-entropy loss accumulator, top level.
// Each pixel item goes, from acceptance until the block is ready again,
// through two passes of the three-stage shared log unit (foreground, then
// background), the weighted pixel term and the saturating add. The pixel
// marked last adds normalizer load, divider setup and 49 steps of the
// one-bit-per-cycle divider, then the result goes to the output register.
// A new item is taken while that result waits; a following last pixel
// holds until the result has been taken.
// Configuration writes are taken in every cycle and belong to idle periods.
module soft_label_cross_entropy_loss
    import slce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    slce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    slce_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: design/slce_checker.sv
// Port-level checks of the soft-label loss block and their bind.
`include "soft_label_cross_entropy_loss_defines.svh"

module slce_checker
    import slce_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    `SLCE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
    `SLCE_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `SLCE_ASSERT_NXT(a_busy_two, in_valid && in_ready, !in_ready ##1 !in_ready)
    `SLCE_ASSERT_IMP(a_out_new_idle, $rose(out_valid), in_ready)

endmodule

bind soft_label_cross_entropy_loss slce_checker u_slce_checker (.*);
